/* rtl/udp_mhp_pkg.sv */
package udp_mhp_pkg;

  localparam int MAX_PACKET_BYTES = 4096;

  // byte counter saturates at the limit, so it must hold the limit itself
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  // arithmetic width: position plus one, and offsets up to extra length + 10
  localparam int CALC_W = ((POS_W > 10) ? POS_W : 10) + 1;
  localparam int OFS_W = 13;

  localparam logic [CALC_W-1:0] MAX_POS = CALC_W'(MAX_PACKET_BYTES);
  localparam logic [CALC_W-1:0] POS_FLAGS = CALC_W'(0);
  localparam logic [CALC_W-1:0] POS_SEQ_LAST = CALC_W'(4);
  localparam logic [CALC_W-1:0] POS_EXTRA = CALC_W'(5);
  localparam logic [CALC_W-1:0] ID_BASE = CALC_W'(6);
  localparam logic [CALC_W-1:0] HIGH_BODY = CALC_W'(7);
  localparam logic [CALC_W-1:0] MED_BODY = CALC_W'(8);
  localparam logic [CALC_W-1:0] LOW_BODY = CALC_W'(10);
  localparam logic [CALC_W-1:0] MIN_LEN = CALC_W'(7);

  localparam logic [7:0] ID_ESCAPE = 8'hff;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_SHORT      = 3'd1,
    ERR_EXTRA      = 3'd2,
    ERR_MED_TRUNC  = 3'd3,
    ERR_LOW_TRUNC  = 3'd4,
    ERR_ACK_FOOTER = 3'd5,
    ERR_BODY       = 3'd6,
    ERR_OVERSIZE   = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    FREQ_HIGH   = 2'd0,
    FREQ_MEDIUM = 2'd1,
    FREQ_LOW    = 2'd2
  } freq_t;

  typedef enum logic [3:0] {
    ID_NONE   = 4'b0001,
    ID_ONE_FF = 4'b0010,
    ID_LOW    = 4'b0100,
    ID_DONE   = 4'b1000
  } id_state_t;

  typedef struct packed {
    err_t        error_code;
    logic        acks_appended;
    logic        is_resent;
    logic        is_reliable;
    logic        is_zero_coded;
    logic [31:0] sequence_number;
    freq_t       frequency_class;
    logic [15:0] message_number;
    logic [OFS_W-1:0] body_start;
    logic [OFS_W-1:0] body_stop;
    logic [7:0]  ack_count;
  } result_t;

  function automatic logic [OFS_W-1:0] to_ofs(input logic [CALC_W-1:0] v);
    logic [CALC_W+OFS_W-1:0] ext;
    ext = {{OFS_W{1'b0}}, v};
    return ext[OFS_W-1:0];
  endfunction

endpackage

/* rtl/udp_mhp_if.sv */
interface udp_mhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface udp_mhp_out_if;
  logic                 valid;
  logic                 ready;
  udp_mhp_pkg::result_t result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

/* rtl/udp_message_header_parser.sv */
// a result is registered in the result register when its final byte moves on from the input register
// throughput: one byte per cycle; a stalled result holds the next final byte in the
// input register, and the input stalls until the result is taken
// the header state updates and the result checks run in one pass between the
// input register and the result register
// reset (rst_n low, synchronous) clears the parse state and empties both registers
module udp_message_header_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  udp_mhp_in_if.sink            in_chan,
  udp_mhp_out_if.source         out_chan
);
  import udp_mhp_pkg::*;

  logic              s1_valid_r;
  logic [7:0]        s1_data_r;
  logic              s1_eop_r;
  logic              s1_adv;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        flags_r, flags_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [7:0]        ext_r, ext_nxt;
  id_state_t         id_st_r, id_st_nxt;
  logic [15:0]       id_r, id_nxt;
  logic [CALC_W-1:0] bo_r, bo_nxt;
  logic              over_r, over_nxt;

  logic              out_valid_r;
  result_t           out_res_r, res_nxt;

  assign s1_adv = s1_valid_r && !(s1_eop_r && out_valid_r && !out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign out_chan.valid = out_valid_r;
  assign out_chan.result = out_res_r;

  // header field capture for the byte in the input register
  always_comb begin
    logic [CALC_W-1:0] pw;
    logic [CALC_W-1:0] e6;
    pw = CALC_W'(pos_r);
    e6 = CALC_W'(ext_r) + ID_BASE;
    pos_nxt = pos_r;
    flags_nxt = flags_r;
    seq_nxt = seq_r;
    ext_nxt = ext_r;
    id_st_nxt = id_st_r;
    id_nxt = id_r;
    bo_nxt = bo_r;
    over_nxt = over_r;
    if (pw >= MAX_POS) begin
      over_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 1'b1;
      priority if (pw == POS_FLAGS) begin
        flags_nxt = s1_data_r[7:4];
      end else if (pw <= POS_SEQ_LAST) begin
        seq_nxt = {seq_r[23:0], s1_data_r};
      end else if (pw == POS_EXTRA) begin
        ext_nxt = s1_data_r;
      end else if (pw < e6) begin
        // extra header bytes are skipped
        ext_nxt = ext_r;
      end else begin
        if (pw == e6 && id_st_r == ID_NONE) begin
          if (s1_data_r != ID_ESCAPE) begin
            id_st_nxt = ID_DONE;
            id_nxt = {8'd0, s1_data_r};
            bo_nxt = CALC_W'(ext_r) + HIGH_BODY;
          end else begin
            id_st_nxt = ID_ONE_FF;
          end
        end else if (pw == e6 + CALC_W'(1) && id_st_r == ID_ONE_FF) begin
          if (s1_data_r != ID_ESCAPE) begin
            id_st_nxt = ID_DONE;
            id_nxt = {8'd0, s1_data_r};
            bo_nxt = CALC_W'(ext_r) + MED_BODY;
          end else begin
            id_st_nxt = ID_LOW;
          end
        end else if (pw == e6 + CALC_W'(2) && id_st_r == ID_LOW) begin
          id_nxt = {s1_data_r, 8'd0};
        end else if (pw == e6 + CALC_W'(3) && id_st_r == ID_LOW) begin
          id_nxt = {id_r[15:8], s1_data_r};
          bo_nxt = CALC_W'(ext_r) + LOW_BODY;
        end
      end
    end
  end

  // end-of-datagram checks on the updated header state
  always_comb begin
    logic [CALC_W-1:0] n;
    logic [CALC_W-1:0] ext7;
    logic [CALC_W-1:0] ext10;
    logic [CALC_W-1:0] ack_bytes;
    logic [CALC_W-1:0] end_ack;
    logic [CALC_W-1:0] end_v;
    logic              acks;
    err_t              err;
    freq_t             cls;
    n = CALC_W'(pos_r) + CALC_W'(1);
    ext7 = CALC_W'(ext_nxt) + HIGH_BODY;
    ext10 = CALC_W'(ext_nxt) + LOW_BODY;
    ack_bytes = CALC_W'({s1_data_r, 2'b00}) + CALC_W'(1);
    end_ack = n - ack_bytes;
    acks = flags_nxt[0];
    end_v = acks ? end_ack : n;
    if (id_st_nxt == ID_LOW) begin
      cls = FREQ_LOW;
    end else if (bo_nxt == ext7) begin
      cls = FREQ_HIGH;
    end else begin
      cls = FREQ_MEDIUM;
    end
    priority if (over_nxt) begin
      err = ERR_OVERSIZE;
    end else if (n < MIN_LEN) begin
      err = ERR_SHORT;
    end else if (n < ext7) begin
      err = ERR_EXTRA;
    end else if (id_st_nxt == ID_NONE) begin
      err = ERR_EXTRA;
    end else if (id_st_nxt == ID_ONE_FF) begin
      err = ERR_MED_TRUNC;
    end else if (id_st_nxt == ID_LOW && n < ext10) begin
      err = ERR_LOW_TRUNC;
    end else if (acks && (ack_bytes > n || end_ack < bo_nxt)) begin
      err = ERR_ACK_FOOTER;
    end else if (bo_nxt > end_v) begin
      err = ERR_BODY;
    end else begin
      err = ERR_OK;
    end
    res_nxt = '0;
    res_nxt.error_code = err;
    if (err == ERR_OK) begin
      res_nxt.acks_appended = flags_nxt[0];
      res_nxt.is_resent = flags_nxt[1];
      res_nxt.is_reliable = flags_nxt[2];
      res_nxt.is_zero_coded = flags_nxt[3];
      res_nxt.sequence_number = seq_nxt;
      res_nxt.frequency_class = cls;
      res_nxt.message_number = id_nxt;
      res_nxt.body_start = to_ofs(bo_nxt);
      res_nxt.body_stop = to_ofs(end_v);
      res_nxt.ack_count = acks ? s1_data_r : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_data_r <= in_chan.data_byte;
      s1_eop_r <= in_chan.end_of_packet;
    end
  end

  // parse state, cleared after every final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_eop_r)) begin
      pos_r <= '0;
      flags_r <= '0;
      seq_r <= '0;
      ext_r <= '0;
      id_st_r <= ID_NONE;
      id_r <= '0;
      bo_r <= '0;
      over_r <= 1'b0;
    end else if (s1_adv) begin
      pos_r <= pos_nxt;
      flags_r <= flags_nxt;
      seq_r <= seq_nxt;
      ext_r <= ext_nxt;
      id_st_r <= id_st_nxt;
      id_r <= id_nxt;
      bo_r <= bo_nxt;
      over_r <= over_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_eop_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_eop_r) begin
      out_res_r <= res_nxt;
    end
  end

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.error_code != ERR_OK |->
      out_res_r.sequence_number == '0 && out_res_r.body_start == '0 &&
      out_res_r.body_stop == '0 && out_res_r.message_number == '0)
    else $error("error result carries nonzero fields");

  a_ack_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.acks_appended |-> out_res_r.ack_count == '0)
    else $error("ack count without ack flag");

  a_oversize_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    over_r |-> CALC_W'(pos_r) == MAX_POS)
    else $error("oversize flag set below the byte limit");

  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_eop_r |=> pos_r == '0 && id_st_r == ID_NONE && !over_r)
    else $error("parse state not cleared after final byte");

endmodule
